/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
		else $error("assertion failed");
// property must hold in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, trig, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
		else $error("assertion failed");
`endif

/* hdl/fpalu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fpalu_pkg;
	localparam int W = 32;
	localparam logic [3:0] CMD_ADD = 4'd0;
	localparam logic [3:0] CMD_SUB = 4'd1;
	localparam logic [3:0] CMD_MUL = 4'd2;
	localparam logic [3:0] CMD_DIV = 4'd3;
	localparam logic [3:0] CMD_MIN = 4'd4;
	localparam logic [3:0] CMD_MAX = 4'd5;
	localparam logic [3:0] CMD_CMP = 4'd6;
	localparam logic [3:0] CMD_I2F = 4'd7;
	localparam logic [3:0] CMD_F2I = 4'd8;
	localparam logic [3:0] CMD_INC = 4'd9;
	localparam logic [3:0] CMD_DEC = 4'd10;

	// flags and final word of one operation
	typedef struct packed {
		logic [W-1:0] value;
		logic         lt;
		logic         eq;
		logic         gt;
		logic         dz;
	} res_t;
endpackage
`default_nettype wire

/* hdl/fpalu_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// one restoring division step per cell, hands remainder and quotient on
module fpalu_div_cell import fpalu_pkg::*; #(
	parameter int NB = 40
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NB-1:0] rem_in,
	input  wire logic [NB-1:0] num_in,
	input  wire logic [W-1:0]  den_in,
	input  wire logic [NB-1:0] quo_in,
	output logic      [NB-1:0] rem_out,
	output logic      [NB-1:0] num_out,
	output logic      [W-1:0]  den_out,
	output logic      [NB-1:0] quo_out
);
	logic [NB:0] sh;
	logic [NB:0] diff;
	logic        take;

	// shift in next numerator bit and try subtract
	always_comb begin
		sh   = {rem_in, num_in[NB-1]};
		diff = sh - {{(NB+1-W){1'b0}}, den_in};
		take = !diff[NB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? diff[NB-1:0] : sh[NB-1:0];
			num_out <= {num_in[NB-2:0], 1'b0};
			den_out <= den_in;
			quo_out <= {quo_in[NB-2:0], take};
		end
	end
endmodule
`default_nettype wire

/* hdl/fixed_point_alu_top.sv */
// fixed_point_alu_top: signed fixed-point alu on 32-bit raw words
// input channel: in_valid/in_stall with command, operand_a, operand_b
// output channel: out_valid/out_stall with result_value and four flags
// an input transfer is taken at a clock edge with valid high, stall low
// every command takes the same path through stage 1, the divider
// cells and the output register, so results leave in order
// throughput: one operation per cycle unless the output stalls; the
// divider is a chain of identical cells, one quotient bit each
// multiply takes the 32x32 magnitude product in stage 1, then sign and shift
// a stall on the output freezes the whole chain, in_stall follows it
// together with a full output register
// reset clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu_top import fpalu_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [3:0]          command,
	input  wire logic signed [W-1:0] operand_a,
	input  wire logic signed [W-1:0] operand_b,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [W-1:0]      result_value,
	output logic                     is_less,
	output logic                     is_equal,
	output logic                     is_greater,
	output logic                     divide_by_zero
);
	localparam int NB = W + FRAC_BITS;
	localparam int NC = NB;
	localparam int LAT = NC + 1;

	// pipeline advances whenever output slot is free or being taken
	logic adv;
	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;
	logic acc;
	assign acc = in_valid && adv;

	// stage 1: decode, simple ops, magnitudes, product
	logic [LAT-1:0]    v_q;
	logic [3:0]        cmd_s1;
	res_t              r_s1;
	logic              neg_s1;
	logic [2*W-1:0]    prod_s1;
	logic [NB-1:0]     num_s1;
	logic [W-1:0]      den_s1;

	logic [W-1:0] ma, mb;
	logic         lt, eq, gt;
	logic [W-1:0] simple;
	always_comb begin
		ma = operand_a[W-1] ? W'(-operand_a) : operand_a;
		mb = operand_b[W-1] ? W'(-operand_b) : operand_b;
		lt = operand_a < operand_b;
		eq = operand_a == operand_b;
		gt = operand_a > operand_b;
		case (command)
			CMD_ADD: simple = operand_a + operand_b;
			CMD_SUB: simple = operand_a - operand_b;
			CMD_MIN: simple = lt ? operand_a : operand_b;
			CMD_MAX: simple = gt ? operand_a : operand_b;
			CMD_I2F: simple = operand_a <<< FRAC_BITS;
			CMD_F2I: simple = operand_a >>> FRAC_BITS;
			CMD_INC: simple = operand_a + W'(1);
			CMD_DEC: simple = operand_a - W'(1);
			default: simple = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= command;
			r_s1     <= '{value: simple, lt: lt, eq: eq, gt: gt,
				dz: (command == CMD_DIV) && (operand_b == '0)};
			neg_s1   <= operand_a[W-1] ^ operand_b[W-1];
			prod_s1  <= ma * mb;
			num_s1   <= {ma, {FRAC_BITS{1'b0}}};
			den_s1   <= mb;
		end
	end

	// divider chain of cells
	logic [NB-1:0] rem_c [NC+1];
	logic [NB-1:0] num_c [NC+1];
	logic [W-1:0]  den_c [NC+1];
	logic [NB-1:0] quo_c [NC+1];
	assign rem_c[0] = '0;
	assign num_c[0] = num_s1;
	assign den_c[0] = den_s1;
	assign quo_c[0] = '0;
	for (genvar i = 0; i < NC; i++) begin : g_cell
		fpalu_div_cell #(.NB(NB)) u_cell (
			.clk(clk), .en(adv),
			.rem_in(rem_c[i]), .num_in(num_c[i]), .den_in(den_c[i]), .quo_in(quo_c[i]),
			.rem_out(rem_c[i+1]), .num_out(num_c[i+1]), .den_out(den_c[i+1]),
			.quo_out(quo_c[i+1])
		);
	end

	// side data travels alongside the cells
	logic [3:0]     cmd_d [NC+1];
	res_t           r_d   [NC+1];
	logic           neg_d [NC+1];
	logic [W-1:0]   mul_d [NC+1];
	logic [2*W-1:0] sp;
	always_comb begin
		sp = neg_s1 ? -prod_s1 : prod_s1;
		cmd_d[0] = cmd_s1;
		r_d[0]   = r_s1;
		neg_d[0] = neg_s1;
		mul_d[0] = sp[FRAC_BITS +: W];
	end
	for (genvar j = 0; j < NC; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				cmd_d[j+1] <= cmd_d[j];
				r_d[j+1]   <= r_d[j];
				neg_d[j+1] <= neg_d[j];
				mul_d[j+1] <= mul_d[j];
			end
		end
	end

	// final select into output register
	logic [W-1:0] qv;
	res_t         fin;
	always_comb begin
		qv  = neg_d[NC] ? W'(-quo_c[NC]) : quo_c[NC][W-1:0];
		fin = r_d[NC];
		if (cmd_d[NC] == CMD_MUL) fin.value = mul_d[NC];
		if (cmd_d[NC] == CMD_DIV) fin.value = fin.dz ? '0 : qv;
	end

	res_t out_q;
	always_ff @(posedge clk) begin
		if (adv) out_q <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q       <= '0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_q       <= {v_q[LAT-2:0], acc};
			out_valid <= v_q[LAT-1];
		end
	end

	assign result_value   = out_q.value;
	assign is_less        = out_q.lt;
	assign is_equal       = out_q.eq;
	assign is_greater     = out_q.gt;
	assign divide_by_zero = out_q.dz;

	`ASSERT_SAME(a_flags_onehot, clk, arst_n, out_valid, $onehot({is_less, is_equal, is_greater}))
	`ASSERT_NEXT(a_hold_stall, clk, arst_n, out_valid && out_stall, out_valid && $stable(v_q))
	`ASSERT_SAME(a_dz_zero, clk, arst_n, out_valid && divide_by_zero, result_value == '0)
endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import fpalu_pkg::*;

	localparam int FRAC = 8;
	localparam int LATENCY = W + FRAC + 3;

	typedef struct packed {
		logic [W-1:0] value;
		logic         lt;
		logic         eq;
		logic         gt;
		logic         dz;
	} alu_out_t;

	int errors = 0;

	task automatic report_mismatch(input string what, input logic [W-1:0] got,
			input logic [W-1:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
	endtask

	// expected alu outputs, oldest first
	class alu_scoreboard;
		alu_out_t pending[$];

		function automatic alu_out_t compute(logic [3:0] cmd, logic signed [W-1:0] a,
				logic signed [W-1:0] b);
			alu_out_t r;
			logic signed [2*W-1:0] prod;
			logic signed [W+FRAC:0] num;
			logic signed [W+FRAC:0] quo;
			r = '0;
			r.lt = a < b;
			r.eq = a == b;
			r.gt = a > b;
			case (cmd)
				CMD_ADD: r.value = a + b;
				CMD_SUB: r.value = a - b;
				CMD_MUL: begin
					prod = 64'(a) * 64'(b);
					prod = prod >>> FRAC;
					r.value = prod[W-1:0];
				end
				CMD_DIV: begin
					if (b == 0) begin
						r.dz = 1'b1;
					end else begin
						num = (W+FRAC+1)'(a) <<< FRAC;
						quo = num / (W+FRAC+1)'(b);
						r.value = quo[W-1:0];
					end
				end
				CMD_MIN: r.value = r.lt ? a : b;
				CMD_MAX: r.value = r.gt ? a : b;
				CMD_I2F: r.value = a << FRAC;
				CMD_F2I: r.value = a >>> FRAC;
				CMD_INC: r.value = a + 1;
				CMD_DEC: r.value = a - 1;
				default: r.value = '0;
			endcase
			return r;
		endfunction

		function void note_transfer(logic [3:0] cmd, logic signed [W-1:0] a,
				logic signed [W-1:0] b);
			pending.push_back(compute(cmd, a, b));
		endfunction

		task check_result(alu_out_t got);
			alu_out_t want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected result", got.value, '0);
			end else begin
				want = pending.pop_front();
				if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
				if (got.lt !== want.lt) report_mismatch("is_less", got.lt, want.lt);
				if (got.eq !== want.eq) report_mismatch("is_equal", got.eq, want.eq);
				if (got.gt !== want.gt) report_mismatch("is_greater", got.gt, want.gt);
				if (got.dz !== want.dz) report_mismatch("divide_by_zero", got.dz, want.dz);
			end
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [3:0] command = '0;
	logic signed [W-1:0] operand_a = '0;
	logic signed [W-1:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [W-1:0] result_value;
	logic is_less, is_equal, is_greater, divide_by_zero;

	alu_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_output = 0;

	fixed_point_alu_top #(.FRAC_BITS(FRAC)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .operand_a(operand_a), .operand_b(operand_b),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_value(result_value), .is_less(is_less), .is_equal(is_equal),
		.is_greater(is_greater), .divide_by_zero(divide_by_zero)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// watchdog
	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// capture input transfers and results
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_transfer(command, operand_a, operand_b);
		if (arst_n && out_valid && !out_stall)
			sb.check_result({result_value, is_less, is_equal, is_greater, divide_by_zero});
	end

	// receiver stall pattern
	always @(negedge clk) begin
		out_stall <= hold_output || ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic signed [W-1:0] pick_operand();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return $signed($urandom_range(2047)) - 1024;
			4: return $signed($urandom_range(65535)) - 32768;
			default: return $urandom;
		endcase
	endfunction

	// offer one item and hold it until the transfer
	task automatic send_op(input logic [3:0] cmd, input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		int guard;
		in_valid <= 1'b0;
		guard = 0;
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(negedge clk);
			guard++;
		end
	endtask

	task automatic run_random(input int count);
		logic [3:0] cmd;
		for (int i = 0; i < count; i++) begin
			cmd = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
				: 4'($urandom_range(10));
			send_op(cmd, pick_operand(), ($urandom_range(9) == 0) ? '0 : pick_operand());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every command on extremes, divide by zero, unused codes
		for (int c = 0; c < 16; c++)
			send_op(4'(c), 32'sh8000_0000, 32'sh7fff_ffff);
		send_op(CMD_DIV, 32'sh0000_0300, '0);
		send_op(CMD_DIV, 32'sh8000_0000, -32'sd1);
		send_op(CMD_MUL, -32'sd1, 32'sd1);
		send_op(CMD_CMP, 32'sd5, 32'sd5);
		send_op(CMD_INC, 32'sh7fff_ffff, '0);
		send_op(CMD_F2I, -32'sd1, '1);
		drain();

		// sender idle and receiver stall phases
		send_idle_pct = 0; recv_stall_pct = 0; run_random(400);
		send_idle_pct = 63; recv_stall_pct = 0; run_random(400);
		send_idle_pct = 0; recv_stall_pct = 63; run_random(400);
		send_idle_pct = 35; recv_stall_pct = 35; run_random(400);
		// sender pauses until everything has come out
		drain();

		// long output hold so the pipeline fills and backs up
		send_idle_pct = 0; recv_stall_pct = 0;
		fork
			begin
				hold_output = 1;
				repeat (3 * LATENCY) @(negedge clk);
				hold_output = 0;
			end
			run_random(300);
		join
		drain();
		repeat (LATENCY + 10) @(negedge clk);

		if (errors == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
